// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks used by the color grading RTL; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NOW(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/rlcg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcg_pkg
// Types, register codes and constant tables of the RGB LUT color grader.
// ----------------------------------------------------------------------------
package rlcg_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_CHAN    = 3;
  localparam int CH_RED      = 0;
  localparam int CH_GREEN    = 1;
  localparam int CH_BLUE     = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_LOOK_MODE      = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRADE_STRENGTH = 8'd1;

  typedef enum logic [2:0] {
    LOOK_IDENTITY = 3'd0,
    LOOK_CONTRAST = 3'd1,
    LOOK_TEAL     = 3'd2,
    LOOK_VINTAGE  = 3'd3,
    LOOK_NEGATIVE = 3'd4
  } look_e;

  typedef struct packed {
    logic                      en;
    logic [7:0]                addr;
    logic [NUM_CHAN-1:0][7:0]  data;
  } lut_wr_t;

  // round(256 * sin(k * pi / 32)), k = 0..16
  function automatic logic [8:0] quarter_sine(input logic [4:0] k);
    logic [8:0] q;
    unique case (k)
      5'd0:    q = 9'd0;
      5'd1:    q = 9'd25;
      5'd2:    q = 9'd50;
      5'd3:    q = 9'd74;
      5'd4:    q = 9'd98;
      5'd5:    q = 9'd121;
      5'd6:    q = 9'd142;
      5'd7:    q = 9'd162;
      5'd8:    q = 9'd181;
      5'd9:    q = 9'd198;
      5'd10:   q = 9'd213;
      5'd11:   q = 9'd226;
      5'd12:   q = 9'd237;
      5'd13:   q = 9'd245;
      5'd14:   q = 9'd251;
      5'd15:   q = 9'd255;
      default: q = 9'd256;
    endcase
    return q;
  endfunction

endpackage

// ===== hdl/rlcg_lut.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcg_lut
// One 256 x 8 channel table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rlcg_lut (
  input  logic       clk,
  input  logic       wr_en,
  input  logic [7:0] wr_addr,
  input  logic [7:0] wr_data,
  input  logic       rd_en,
  input  logic [7:0] rd_addr,
  output logic [7:0] rd_data
);
  logic [7:0] mem [256];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/rlcg_curve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcg_curve
// Config registers and table rebuild: sweep entries through a 5-stage curve
// and blend pipeline and emit one table write per cycle.
// ----------------------------------------------------------------------------
module rlcg_curve (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr,
  input  logic [rlcg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rlcg_pkg::CFG_DATA_W-1:0]     cfg_data,
  output rlcg_pkg::lut_wr_t                   tbl_wr,
  output logic                                sweep_busy
);
  import rlcg_pkg::*;

  logic [2:0] look_mode;
  logic [8:0] grade_strength;
  logic       cfg_hit;

  logic       sweeping;
  logic [7:0] idx;
  logic [8:0] t0;

  logic        s1_valid, s2_valid, s3_valid, s4_valid;
  logic [7:0]  s1_idx, s2_idx, s3_idx, s4_idx;
  logic [8:0]  s1_t, s2_t;
  logic [16:0] s1_tt;
  logic [9:0]  s1_m;
  logic [8:0]  s1_hump;

  logic [8:0]  s2_con;
  logic [4:0]  s2_s31;
  logic [4:0]  s2_w26;
  logic [7:0]  s2_l205;
  logic [7:0]  s2_l195;

  logic signed [17:0] s3_diff [NUM_CHAN];
  logic signed [27:0] s4_v    [NUM_CHAN];

  // stage 1 comb
  logic [7:0]  hq;
  logic [8:0]  qk, qk1;
  logic [11:0] hprod;
  logic [17:0] tt_full;

  // stage 2 comb
  logic [26:0] con_prod;
  logic [12:0] s31_prod, w26_prod;
  logic [16:0] p205, p195;

  // stage 3 comb
  logic [9:0]         teal_red_raw;
  logic signed [10:0] teal_blue_raw;
  logic [8:0]         teal_red, teal_blue;
  logic [8:0]         look [NUM_CHAN];

  // stage 4 comb
  logic signed [9:0]  gs_s;
  logic signed [27:0] v_next [NUM_CHAN];

  // stage 5 comb
  logic [NUM_CHAN-1:0][7:0] entry;

  function automatic logic signed [17:0] blend_diff(input logic [8:0] l, input logic [7:0] i);
    logic signed [17:0] l255;
    logic signed [17:0] i256;
    l255 = $signed({1'b0, l, 8'd0}) - $signed({9'd0, l});
    i256 = $signed({2'b00, i, 8'd0});
    return l255 - i256;
  endfunction

  assign cfg_hit = cfg_wr && (cfg_index == REG_LOOK_MODE || cfg_index == REG_GRADE_STRENGTH);
  assign t0 = {1'b0, idx} + {8'd0, idx[7]};

  always_ff @(posedge clk) begin
    tbl_wr.addr <= s4_idx;
    tbl_wr.data <= entry;
    if (rst) begin
      look_mode      <= LOOK_IDENTITY;
      grade_strength <= 9'd0;
      sweeping       <= 1'b1;
      idx            <= 8'd0;
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      s3_valid       <= 1'b0;
      s4_valid       <= 1'b0;
      tbl_wr.en      <= 1'b0;
    end else if (cfg_hit) begin
      if (cfg_index == REG_LOOK_MODE) begin
        look_mode <= cfg_data[2:0];
      end else begin
        grade_strength <= cfg_data[8:0];
      end
      sweeping  <= 1'b1;
      idx       <= 8'd0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      tbl_wr.en <= 1'b0;
    end else begin
      if (sweeping) begin
        idx <= idx + 8'd1;
        if (idx == 8'hFF) begin
          sweeping <= 1'b0;
        end
      end
      s1_valid  <= sweeping;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      tbl_wr.en <= s4_valid;
    end
  end

  assign sweep_busy = sweeping | s1_valid | s2_valid | s3_valid | s4_valid | tbl_wr.en;

  // stage 1: square, contrast factor, sine hump
  always_comb begin
    hq      = (t0 <= 9'd128) ? t0[7:0] : 8'(9'd256 - t0);
    qk      = quarter_sine(hq[7:3]);
    qk1     = quarter_sine(hq[7:3] + 5'd1);
    hprod   = 12'(qk1 - qk) * {9'd0, hq[2:0]};
    tt_full = 18'(t0) * 18'(t0);
  end

  always_ff @(posedge clk) begin
    s1_idx  <= idx;
    s1_t    <= t0;
    s1_tt   <= tt_full[16:0];
    s1_m    <= 10'd768 - {t0, 1'b0};
    s1_hump <= qk + {3'd0, hprod[8:3]};
  end

  // stage 2: constant scalings and contrast product
  always_comb begin
    con_prod = 27'(s1_tt) * 27'(s1_m);
    s31_prod = 13'(s1_hump) * 13'd31;
    w26_prod = 13'(9'd256 - s1_t) * 13'd26;
    p205     = 17'(s1_t) * 17'd205;
    p195     = 17'(s1_t) * 17'd195;
  end

  always_ff @(posedge clk) begin
    s2_idx  <= s1_idx;
    s2_t    <= s1_t;
    s2_con  <= con_prod[24:16];
    s2_s31  <= s31_prod[12:8];
    s2_w26  <= w26_prod[12:8];
    s2_l205 <= p205[15:8];
    s2_l195 <= p195[15:8];
  end

  // stage 3: select look curve, form blend difference
  always_comb begin
    teal_red_raw  = {1'b0, s2_t} + {5'd0, s2_s31};
    teal_red      = (teal_red_raw > 10'd256) ? 9'd256 : teal_red_raw[8:0];
    teal_blue_raw = $signed({2'b00, s2_t}) - $signed({6'd0, s2_s31})
                  + $signed({6'd0, s2_w26});
    if (teal_blue_raw < 0) begin
      teal_blue = 9'd0;
    end else if (teal_blue_raw > 11'sd256) begin
      teal_blue = 9'd256;
    end else begin
      teal_blue = teal_blue_raw[8:0];
    end
    unique case (look_mode)
      LOOK_CONTRAST: begin
        look[CH_RED]   = s2_con;
        look[CH_GREEN] = s2_con;
        look[CH_BLUE]  = s2_con;
      end
      LOOK_TEAL: begin
        look[CH_RED]   = teal_red;
        look[CH_GREEN] = s2_t;
        look[CH_BLUE]  = teal_blue;
      end
      LOOK_VINTAGE: begin
        look[CH_RED]   = 9'd41 + {1'b0, s2_l205};
        look[CH_GREEN] = 9'd31 + {1'b0, s2_l205};
        look[CH_BLUE]  = 9'd31 + {1'b0, s2_l195};
      end
      LOOK_NEGATIVE: begin
        look[CH_RED]   = 9'd256 - s2_t;
        look[CH_GREEN] = 9'd256 - s2_t;
        look[CH_BLUE]  = 9'd256 - s2_t;
      end
      default: begin
        look[CH_RED]   = s2_t;
        look[CH_GREEN] = s2_t;
        look[CH_BLUE]  = s2_t;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s3_idx <= s2_idx;
    for (int c = 0; c < NUM_CHAN; c++) begin
      s3_diff[c] <= blend_diff(look[c], s2_idx);
    end
  end

  // stage 4: weight by strength
  always_comb begin
    gs_s = $signed({1'b0, grade_strength});
    for (int c = 0; c < NUM_CHAN; c++) begin
      v_next[c] = $signed({4'd0, s3_idx, 16'd0}) + 28'(s3_diff[c]) * 28'(gs_s);
    end
  end

  always_ff @(posedge clk) begin
    s4_idx <= s3_idx;
    for (int c = 0; c < NUM_CHAN; c++) begin
      s4_v[c] <= v_next[c];
    end
  end

  // stage 5: truncate and clamp
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (s4_v[c][27] || s4_v[c] == 28'sd0) begin
        entry[c] = 8'd0;
      end else if (|s4_v[c][26:24]) begin
        entry[c] = 8'hFF;
      end else begin
        entry[c] = s4_v[c][23:16];
      end
    end
  end

endmodule

// ===== hdl/rgb_lut_color_grading.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_lut_color_grading
// Per-channel 1D LUT color grader for RGB888 pixels with table rebuild.
// ----------------------------------------------------------------------------
//  channel   signals                                    handshake
//  pixel in  red_in, green_in, blue_in                  start & !busy
//  pixel out red_out, green_out, blue_out               done strobe, 1 cycle
//  config    cfg_index, cfg_data                        cfg_valid & cfg_ready
//
//  One pixel per clock unless busy; result strobes the cycle after accept
//  (table read). Reset and each write to a defined register rebuild all
//  three tables: 256 entries swept through a 5-stage pipeline, busy from
//  reset release or the write cycle (itself busy) until all are written.
//  Config is always ready; the output side has no backpressure.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_lut_color_grading (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [7:0]                        red_in,
  input  logic [7:0]                        green_in,
  input  logic [7:0]                        blue_in,
  output logic                              done,
  output logic [7:0]                        red_out,
  output logic [7:0]                        green_out,
  output logic [7:0]                        blue_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rlcg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rlcg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rlcg_pkg::*;

  lut_wr_t tbl_wr;
  logic    sweep_busy;
  logic    accept;
  logic    cfg_hit;

  assign cfg_ready = 1'b1;
  assign busy      = rst | cfg_valid | sweep_busy;
  assign accept    = start & ~busy;
  assign cfg_hit   = cfg_valid && (cfg_index == REG_LOOK_MODE ||
                                   cfg_index == REG_GRADE_STRENGTH);

  rlcg_curve u_curve (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tbl_wr     (tbl_wr),
    .sweep_busy (sweep_busy)
  );

  rlcg_lut u_lut_red (
    .clk     (clk),
    .wr_en   (tbl_wr.en),
    .wr_addr (tbl_wr.addr),
    .wr_data (tbl_wr.data[CH_RED]),
    .rd_en   (accept),
    .rd_addr (red_in),
    .rd_data (red_out)
  );

  rlcg_lut u_lut_green (
    .clk     (clk),
    .wr_en   (tbl_wr.en),
    .wr_addr (tbl_wr.addr),
    .wr_data (tbl_wr.data[CH_GREEN]),
    .rd_en   (accept),
    .rd_addr (green_in),
    .rd_data (green_out)
  );

  rlcg_lut u_lut_blue (
    .clk     (clk),
    .wr_en   (tbl_wr.en),
    .wr_addr (tbl_wr.addr),
    .wr_data (tbl_wr.data[CH_BLUE]),
    .rd_en   (accept),
    .rd_addr (blue_in),
    .rd_data (blue_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  `ASSERT_NEXT(a_done_follows, clk, rst, accept, done)
  `ASSERT_NEXT(a_no_spurious, clk, rst, !accept, !done)
  `ASSERT_NEXT(a_cfg_rebuild, clk, rst, cfg_hit, busy)
  `ASSERT_NOW(a_no_read_on_write, clk, rst, tbl_wr.en, !accept)

endmodule
